// ===== hw/rtl/pldrv_pkg.sv =====
// ----------------------------------------------------------------------------
// pldrv_pkg
// Shared types, widths and helpers for the line follower drive unit.
// ----------------------------------------------------------------------------
package pldrv_pkg;

   // Accumulator width of the trapezoidal integral.
   localparam int SUM_WIDTH  = 24;
   // Fraction bits of the Q8.8 gains.
   localparam int FRAC_BITS  = 8;

   // Operand and product widths, derived from the field widths.
   localparam int GAIN_W     = 16;
   localparam int ERR_W      = 8;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int PROD_P_W   = GAIN_W + ERR_W;
   localparam int PROD_I_W   = GAIN_W + SUM_WIDTH;
   localparam int PROD_D_W   = GAIN_W + DIFF_W;
   localparam int Q_W        = PROD_I_W + 2;
   localparam int CORR_W     = Q_W - FRAC_BITS;
   localparam int DRV_W      = CORR_W + 2;

   // Configuration port widths.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Wheel command limits.
   localparam logic signed [7:0]       DRIVE_HI = 8'sd100;
   localparam logic signed [7:0]       DRIVE_LO = -8'sd100;
   localparam logic signed [DRV_W-1:0] DRV_MAX  = DRV_W'(100);
   localparam logic signed [DRV_W-1:0] DRV_MIN  = -DRV_MAX;

   // Accumulator limits.
   localparam logic signed [SUM_WIDTH:0] SUM_MAX = (SUM_WIDTH+1)'((64'sd1 <<< (SUM_WIDTH-1)) - 1);
   localparam logic signed [SUM_WIDTH:0] SUM_MIN = -SUM_MAX - (SUM_WIDTH+1)'(1);

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_LEVEL = 3'd0,
      CSR_BASE_POWER   = 3'd1,
      CSR_PROP_GAIN    = 3'd2,
      CSR_INTEG_GAIN   = 3'd3,
      CSR_DERIV_GAIN   = 3'd4,
      CSR_TURN_OFFSET  = 3'd5,
      CSR_FOLLOW_SIDE  = 3'd6
   } csr_index_type;

   // Clamp a wide wheel command to the +-100 range.
   function automatic logic signed [7:0] sat_drive(input logic signed [DRV_W-1:0] v);
      logic signed [7:0] r;
      if (v > DRV_MAX) begin
         r = DRIVE_HI;
      end else if (v < DRV_MIN) begin
         r = DRIVE_LO;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/pid_line_follower_drive_unit.sv =====
// ----------------------------------------------------------------------------
// pid_line_follower_drive_unit
// Line follower PID drive: trapezoidal integral, Q8.8 gains, two wheel outputs.
// ----------------------------------------------------------------------------
// Path: an accepted request enters an input register holding error and
// integral, then the result register, which raises rsp_valid; rsp_stall can hold it.
// Throughput: one request per cycle; req_stall rises only when both registers
// are full and rsp_stall is high.
// Reset: registers return to their defaults (target 50, all else zero),
// integral and last error clear, and both stages empty.
module pid_line_follower_drive_unit
   import pldrv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [6:0]             req_brightness,
   // Result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [7:0]      rsp_left_drive,
   output logic signed [7:0]      rsp_right_drive,
   // Configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers.
   logic [6:0]               target_level_ff;
   logic signed [7:0]        base_power_ff;
   logic signed [GAIN_W-1:0] prop_gain_ff;
   logic signed [GAIN_W-1:0] integ_gain_ff;
   logic signed [GAIN_W-1:0] deriv_gain_ff;
   logic signed [8:0]        turn_offset_ff;
   logic                     follow_side_ff;

   // Controller state.
   logic signed [SUM_WIDTH-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]     last_error_ff, err_in;
   logic signed [DIFF_W-1:0]    diff_in;
   logic signed [SUM_WIDTH:0]   sum_raw;

   // Input register: error, integral and difference.
   logic                        s1_valid_ff;
   logic signed [ERR_W-1:0]     s1_err_ff;
   logic signed [SUM_WIDTH-1:0] s1_sum_ff;
   logic signed [DIFF_W-1:0]    s1_diff_ff;

   // Gain products.
   logic signed [PROD_P_W-1:0]  prod_p;
   logic signed [PROD_I_W-1:0]  prod_i;
   logic signed [PROD_D_W-1:0]  prod_d;

   // Result register.
   logic                        rsp_valid_ff;
   logic signed [7:0]           rsp_left_ff, rsp_left_in;
   logic signed [7:0]           rsp_right_ff, rsp_right_in;

   logic out_ready, s1_ready, req_accept;
   logic signed [Q_W-1:0]    q_sum;
   logic signed [CORR_W-1:0] corr;
   logic signed [7:0]        half_turn;
   logic signed [DRV_W-1:0]  drive_minus, drive_plus;

   // Flow control: a stage loads when it is empty or its successor is
   // taking its contents.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_ready   = !s1_valid_ff || out_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign csr_ready  = 1'b1;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_level_ff <= 7'd50;
         base_power_ff   <= '0;
         prop_gain_ff    <= '0;
         integ_gain_ff   <= '0;
         deriv_gain_ff   <= '0;
         turn_offset_ff  <= '0;
         follow_side_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TARGET_LEVEL: target_level_ff <= csr_data[6:0];
            CSR_BASE_POWER:   base_power_ff   <= csr_data[7:0];
            CSR_PROP_GAIN:    prop_gain_ff    <= csr_data;
            CSR_INTEG_GAIN:   integ_gain_ff   <= csr_data;
            CSR_DERIV_GAIN:   deriv_gain_ff   <= csr_data;
            CSR_TURN_OFFSET:  turn_offset_ff  <= csr_data[8:0];
            CSR_FOLLOW_SIDE:  follow_side_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Error, saturating trapezoidal integral and error difference.
   always_comb begin
      err_in  = $signed({1'b0, req_brightness}) - $signed({1'b0, target_level_ff});
      diff_in = DIFF_W'(err_in) - DIFF_W'(last_error_ff);
      sum_raw = (SUM_WIDTH+1)'(error_sum_ff) + (SUM_WIDTH+1)'(err_in)
                + (SUM_WIDTH+1)'(last_error_ff);
      if (sum_raw > SUM_MAX) begin
         error_sum_in = SUM_MAX[SUM_WIDTH-1:0];
      end else if (sum_raw < SUM_MIN) begin
         error_sum_in = SUM_MIN[SUM_WIDTH-1:0];
      end else begin
         error_sum_in = sum_raw[SUM_WIDTH-1:0];
      end
   end

   // Controller state advances with each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         last_error_ff <= '0;
      end else if (req_accept) begin
         error_sum_ff  <= error_sum_in;
         last_error_ff <= err_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff  <= err_in;
         s1_sum_ff  <= error_sum_in;
         s1_diff_ff <= diff_in;
      end
   end

   // Three independent gain multiplies.
   assign prod_p = PROD_P_W'(prop_gain_ff)  * PROD_P_W'(s1_err_ff);
   assign prod_i = PROD_I_W'(integ_gain_ff) * PROD_I_W'(s1_sum_ff);
   assign prod_d = PROD_D_W'(deriv_gain_ff) * PROD_D_W'(s1_diff_ff);

   // Sum the products, floor to an integer and form both wheel commands.
   always_comb begin
      q_sum       = Q_W'(prod_p) + Q_W'(prod_i) + Q_W'(prod_d);
      corr        = $signed(q_sum[Q_W-1:FRAC_BITS]);
      half_turn   = $signed(turn_offset_ff[8:1]);
      drive_minus = DRV_W'(base_power_ff) - DRV_W'(corr) + DRV_W'(half_turn);
      drive_plus  = DRV_W'(base_power_ff) + DRV_W'(corr) - DRV_W'(half_turn);
      if (follow_side_ff) begin
         rsp_left_in  = sat_drive(drive_plus);
         rsp_right_in = sat_drive(drive_minus);
      end else begin
         rsp_left_in  = sat_drive(drive_minus);
         rsp_right_in = sat_drive(drive_plus);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_left_ff  <= rsp_left_in;
         rsp_right_ff <= rsp_right_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_drive  = rsp_left_ff;
   assign rsp_right_drive = rsp_right_ff;

endmodule
